// ----- design/rptc_pkg.sv -----
// ----------------------------------------------------------------------------
// rptc_pkg
// Shared constants, command codes and result layout for the ripple peak
// travel counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rptc_pkg;

  localparam int unsigned SAMPLE_BITS    = 10;
  localparam int unsigned REFR_BITS      = 5;
  localparam int unsigned REFRACTORY_CAP = 16;
  localparam int unsigned SPACING_BITS   = 4;
  localparam int unsigned COUNT_BITS     = 16;
  localparam int unsigned TARGET_BITS    = 15;
  localparam int unsigned POS_BITS       = 16;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [SPACING_BITS-1:0] SPACING_RESET = SPACING_BITS'(3);

  typedef enum logic [IN_TUSER_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_START  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic                       [4:0] pad;
    logic signed [POS_BITS-1:0]       position;
    logic        [COUNT_BITS-1:0]     peaks_counted;
    logic                             counting_active;
    logic                             stop_motor;
    logic                             peak_seen;
  } result_t;

endpackage

`default_nettype wire

// ----- design/rptc_out_buf.sv -----
// ----------------------------------------------------------------------------
// rptc_out_buf
// Two-entry result buffer: output register plus skid stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rptc_out_buf (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [rptc_pkg::OUT_TDATA_W-1:0] in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [rptc_pkg::OUT_TDATA_W-1:0] out_data_o
);
  import rptc_pkg::*;

  logic                   out_valid_q, out_valid_d;
  logic                   skid_valid_q, skid_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic [OUT_TDATA_W-1:0] skid_data_q, skid_data_d;
  logic                   push, pop;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (push) begin
      if (!out_valid_q || (pop && !skid_valid_q)) begin
        out_data_d  = in_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = in_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule

`default_nettype wire

// ----- design/ripple_peak_travel_counter_core.sv -----
// ----------------------------------------------------------------------------
// ripple_peak_travel_counter_core
// Counts motor current ripple peaks and tracks signed actuator travel.
// ----------------------------------------------------------------------------
// Each accepted sample beat updates the window, refractory count, peak count
// and position in the cycle it is accepted; start beats set the target and
// clear beats clear the count and position. Every beat yields one result
// via a two-entry output buffer; a new beat is taken every cycle until
// two results are pending. min_peak_spacing is written through cfg_we_i;
// the user must write it only while idle, the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module ripple_peak_travel_counter_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [rptc_pkg::SPACING_BITS-1:0]    cfg_wdata_i,
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // [9:0] current_sample, [24:10] travel_count, [25] retract, [31:26] zero
  input  wire logic [rptc_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // [1:0] command
  input  wire logic [rptc_pkg::IN_TUSER_W-1:0]      s_axis_tuser_i,
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  // [0] peak_seen, [1] stop_motor, [2] counting_active, [18:3] peaks_counted,
  // [34:19] position, [39:35] zero
  output logic      [rptc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);
  import rptc_pkg::*;

  logic [SPACING_BITS-1:0] spacing_q;
  logic [SAMPLE_BITS-1:0]  w1_q, w1_d, w2_q, w2_d;
  logic [REFR_BITS-1:0]    refr_q, refr_d, refr_inc;
  logic [COUNT_BITS-1:0]   count_q, count_d, count_pk;
  logic                    armed_q, armed_d;
  logic [POS_BITS-1:0]     pos_q, pos_d, pos_pk;
  logic [TARGET_BITS-1:0]  target_q, target_d;
  logic                    retr_q, retr_d;
  logic                    accept, peak, stop, is_peak;
  logic [SAMPLE_BITS-1:0]  smp;
  cmd_e                    cmd;
  result_t                 res;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd    = cmd_e'(s_axis_tuser_i);
  assign smp    = s_axis_tdata_i[SAMPLE_BITS-1:0];

  assign refr_inc = (refr_q < REFR_BITS'(REFRACTORY_CAP)) ? refr_q + REFR_BITS'(1) : refr_q;
  assign is_peak  = (w1_q != '0) &&
                    (((w2_q >= w1_q) && (w2_q > smp)) || ((w2_q > w1_q) && (w2_q >= smp)));

  always_comb begin
    w1_d     = w1_q;
    w2_d     = w2_q;
    refr_d   = refr_q;
    count_d  = count_q;
    armed_d  = armed_q;
    pos_d    = pos_q;
    target_d = target_q;
    retr_d   = retr_q;
    peak     = 1'b0;
    stop     = 1'b0;
    count_pk = count_q;
    pos_pk   = pos_q;
    case (cmd)
      CMD_SAMPLE: begin
        w1_d   = w2_q;
        w2_d   = smp;
        refr_d = refr_inc;
        peak   = is_peak && armed_q && (refr_inc > {1'b0, spacing_q});
        if (peak) begin
          count_pk = count_q + COUNT_BITS'(1);
          pos_pk   = retr_q ? pos_q - POS_BITS'(1) : pos_q + POS_BITS'(1);
          refr_d   = '0;
        end
        stop    = count_pk > {1'b0, target_q};
        count_d = stop ? '0 : count_pk;
        armed_d = stop ? 1'b0 : armed_q;
        if (stop) begin
          pos_d = retr_q ? pos_pk + POS_BITS'(1) : pos_pk - POS_BITS'(1);
        end else begin
          pos_d = pos_pk;
        end
      end
      CMD_START: begin
        target_d = s_axis_tdata_i[SAMPLE_BITS +: TARGET_BITS];
        retr_d   = s_axis_tdata_i[SAMPLE_BITS + TARGET_BITS];
        armed_d  = 1'b1;
        count_d  = '0;
      end
      CMD_CLEAR: begin
        count_d = '0;
        pos_d   = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res                 = '0;
    res.peak_seen       = peak;
    res.stop_motor      = stop;
    res.counting_active = armed_d;
    res.peaks_counted   = count_d;
    res.position        = signed'(pos_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= SPACING_RESET;
    end else if (cfg_we_i) begin
      spacing_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q     <= '0;
      w2_q     <= '0;
      refr_q   <= '0;
      count_q  <= '0;
      armed_q  <= 1'b0;
      pos_q    <= '0;
      target_q <= '0;
      retr_q   <= 1'b0;
    end else if (accept) begin
      w1_q     <= w1_d;
      w2_q     <= w2_d;
      refr_q   <= refr_d;
      count_q  <= count_d;
      armed_q  <= armed_d;
      pos_q    <= pos_d;
      target_q <= target_d;
      retr_q   <= retr_d;
    end
  end

  rptc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

`ifndef SYNTH
  a_refr_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refr_q <= REFR_BITS'(REFRACTORY_CAP))
    else $error("refractory count above cap");

  a_stop_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && stop) |=> (!armed_q && (count_q == '0)))
    else $error("stop did not disarm and clear count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= {1'b0, target_q} || !armed_q || count_q == '0)
    else $error("peak count beyond target while armed");

  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");
`endif

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the ripple peak travel counter against its own cycle-free model.
// A directed stretch hits window shapes, plateaus, a zero oldest sample,
// refractory blocking, target stops and every command. Random ripple
// waveforms with random start, clear, reserved and noise beats then run under
// several peak spacing settings. The sender runs in bursts and the receiver
// stalls on its own patterns.
// ----------------------------------------------------------------------------

module testbench;
  import rptc_pkg::*;

  class travel_scoreboard;
    logic [SAMPLE_BITS-1:0]  window [3];
    logic [REFR_BITS-1:0]    refractory;
    logic [COUNT_BITS-1:0]   peaks;
    logic [POS_BITS-1:0]     position;
    logic [TARGET_BITS-1:0]  target;
    logic [SPACING_BITS-1:0] spacing;
    bit                      armed;
    bit                      retracting;
    result_t                 expected_q[$];
    int                      errors;

    function new();
      window     = '{default: '0};
      refractory = '0;
      peaks      = '0;
      position   = '0;
      target     = '0;
      spacing    = SPACING_RESET;
      armed      = 1'b0;
      retracting = 1'b0;
      errors     = 0;
    endfunction

    function void set_spacing(logic [SPACING_BITS-1:0] value);
      spacing = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_beat(cmd_e cmd, logic [SAMPLE_BITS-1:0] sample,
                            logic [TARGET_BITS-1:0] count, logic retract);
      result_t r;
      logic    is_peak;
      r = '0;
      case (cmd)
        CMD_SAMPLE: begin
          if (refractory < REFR_BITS'(REFRACTORY_CAP))
            refractory = refractory + REFR_BITS'(1);
          window[0] = window[1];
          window[1] = window[2];
          window[2] = sample;
          is_peak = (window[0] != '0) &&
                    ((window[1] >= window[0] && window[1] > window[2]) ||
                     (window[1] > window[0] && window[1] >= window[2]));
          if (is_peak && armed && refractory > {1'b0, spacing}) begin
            peaks       = peaks + COUNT_BITS'(1);
            position    = retracting ? position - POS_BITS'(1) : position + POS_BITS'(1);
            refractory  = '0;
            r.peak_seen = 1'b1;
          end
          if (peaks > {1'b0, target}) begin
            armed        = 1'b0;
            peaks        = '0;
            position     = retracting ? position + POS_BITS'(1) : position - POS_BITS'(1);
            r.stop_motor = 1'b1;
          end
        end
        CMD_START: begin
          target     = count;
          retracting = retract;
          armed      = 1'b1;
          peaks      = '0;
        end
        CMD_CLEAR: begin
          peaks    = '0;
          position = '0;
        end
        default: ;
      endcase
      r.counting_active = armed;
      r.peaks_counted   = peaks;
      r.position        = position;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      result_t got;
      result_t exp;
      got = result_t'(data);
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %h", data);
        return;
      end
      exp = expected_q.pop_front();
      if (got.peak_seen !== exp.peak_seen || got.stop_motor !== exp.stop_motor ||
          got.counting_active !== exp.counting_active ||
          got.peaks_counted !== exp.peaks_counted ||
          got.position !== exp.position || got.pad !== exp.pad) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp peak=%b stop=%b act=%b cnt=%0d pos=%0d pad=%h",
                   exp.peak_seen, exp.stop_motor, exp.counting_active,
                   exp.peaks_counted, exp.position, exp.pad,
                   " | got peak=%b stop=%b act=%b cnt=%0d pos=%0d pad=%h",
                   got.peak_seen, got.stop_motor, got.counting_active,
                   got.peaks_counted, got.position, got.pad);
      end
    endfunction
  endclass

  typedef enum int {RX_FLOW, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [SPACING_BITS-1:0] cfg_wdata = '0;
  logic                    s_valid = 1'b0;
  logic                    s_ready;
  logic [IN_TDATA_W-1:0]   s_data = '0;
  logic [IN_TUSER_W-1:0]   s_user = '0;
  logic                    m_valid;
  logic                    m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_data;

  travel_scoreboard sb = new();

  int       burst_left = 0;
  int       ripple_level = 200;
  int       ripple_slope = 1;
  int       ripple_run = 0;
  rx_mode_e rx_mode = RX_FLOW;
  int       rx_left = 0;
  int       rx_tick = 0;
  int       rx_period = 4;
  int       rx_hold = 1;

  ripple_peak_travel_counter_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      rx_left   = $urandom_range(20, 200);
      rx_period = $urandom_range(2, 8);
      rx_hold   = $urandom_range(1, rx_period - 1);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_FLOW:   m_ready <= 1'b1;
      RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
      RX_MOSTLY: m_ready <= ($urandom_range(0, 4) != 0);
      default:   m_ready <= (rx_tick % rx_period) >= rx_hold;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) sb.check_result(m_data);
  end

  task automatic send_beat(cmd_e cmd, logic [SAMPLE_BITS-1:0] sample,
                           logic [TARGET_BITS-1:0] count, logic retract);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= {6'b0, retract, count, sample};
    s_user  <= cmd;
    do @(posedge clk_i); while (!s_ready);
    sb.note_beat(cmd, sample, count, retract);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_spacing(logic [SPACING_BITS-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    sb.set_spacing(value);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] next_ripple();
    if (ripple_run == 0) begin
      ripple_run   = $urandom_range(1, 10);
      ripple_slope = ($urandom_range(0, 6) == 0) ? 0 : (ripple_slope > 0 ? -1 : 1);
      if (ripple_slope == 0) ripple_run = $urandom_range(1, 2);
    end
    ripple_run--;
    ripple_level += ripple_slope * int'($urandom_range(1, 60));
    if (ripple_level < 0) ripple_level = 0;
    if (ripple_level > 1023) ripple_level = 1023;
    if ($urandom_range(0, 32) == 0) return '0;
    return SAMPLE_BITS'(ripple_level);
  endfunction

  task automatic run_random(int n);
    int                     pick;
    logic [TARGET_BITS-1:0] count;
    for (int i = 0; i < n; i++) begin
      pick  = $urandom_range(0, 99);
      count = TARGET_BITS'($urandom_range(0, 32767));
      if (pick < 4) begin
        if ($urandom_range(0, 9) < 7) count = TARGET_BITS'($urandom_range(0, 12));
        else if ($urandom_range(0, 2) != 0) count = TARGET_BITS'($urandom_range(0, 200));
        send_beat(CMD_START, SAMPLE_BITS'($urandom), count, 1'($urandom));
      end else if (pick < 6) begin
        send_beat(CMD_CLEAR, SAMPLE_BITS'($urandom), count, 1'($urandom));
      end else if (pick < 7) begin
        send_beat(CMD_RSVD, SAMPLE_BITS'($urandom), count, 1'($urandom));
      end else if (pick < 9) begin
        send_beat(CMD_SAMPLE, SAMPLE_BITS'($urandom), count, 1'($urandom));
      end else begin
        send_beat(CMD_SAMPLE, next_ripple(), count, 1'($urandom));
      end
    end
  endtask

  initial begin
    #4ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_beat(CMD_SAMPLE, 10'd1023, 15'd0,     1'b0);
    send_beat(CMD_START,  10'd0,    15'd32767, 1'b1);
    send_beat(CMD_SAMPLE, 10'd0,    15'd0,     1'b0);
    send_beat(CMD_SAMPLE, 10'd40,   15'd0,     1'b0);
    send_beat(CMD_SAMPLE, 10'd10,   15'd0,     1'b0);
    send_beat(CMD_SAMPLE, 10'd10,   15'd0,     1'b0);
    send_beat(CMD_SAMPLE, 10'd300,  15'd0,     1'b0);
    send_beat(CMD_SAMPLE, 10'd300,  15'd0,     1'b0);
    send_beat(CMD_SAMPLE, 10'd100,  15'd0,     1'b0);
    send_beat(CMD_SAMPLE, 10'd100,  15'd0,     1'b0);
    send_beat(CMD_SAMPLE, 10'd100,  15'd0,     1'b0);
    send_beat(CMD_SAMPLE, 10'd500,  15'd0,     1'b0);
    send_beat(CMD_SAMPLE, 10'd500,  15'd0,     1'b0);
    send_beat(CMD_SAMPLE, 10'd20,   15'd0,     1'b0);
    send_beat(CMD_RSVD,   10'd1023, 15'd32767, 1'b1);
    send_beat(CMD_CLEAR,  10'd1023, 15'd32767, 1'b1);
    send_beat(CMD_START,  10'd0,    15'd0,     1'b0);
    send_beat(CMD_SAMPLE, 10'd1023, 15'd0,     1'b0);
    send_beat(CMD_SAMPLE, 10'd2,    15'd0,     1'b0);
    send_beat(CMD_SAMPLE, 10'd700,  15'd0,     1'b0);
    send_beat(CMD_START,  10'd0,    15'd1,     1'b1);
    send_beat(CMD_SAMPLE, 10'd900,  15'd0,     1'b0);
    send_beat(CMD_SAMPLE, 10'd100,  15'd0,     1'b0);
    send_beat(CMD_CLEAR,  10'd0,    15'd0,     1'b0);

    write_spacing(4'd0);
    run_random(450);
    write_spacing(4'd15);
    run_random(450);
    write_spacing(4'd7);
    run_random(450);
    write_spacing(SPACING_BITS'($urandom_range(1, 14)));
    run_random(500);

    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
